@@ rtl/core/lmbs_pkg.sv @@
// Shared types and constants for the LED matrix bit-plane scanner.
package lmbs_pkg;

    // Field widths fixed by the stream payload
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Compare value loaded when scanning is switched back on
    localparam logic [BYTE_W-1:0] INITIAL_COMPARE = 8'd20;
    // Row at which the second row shift register is loaded
    localparam logic [ROW_W-1:0]  SECOND_BANK_ROW = 4'd8;

    // Reset values of the plane periods
    localparam logic [BYTE_W-1:0] PERIOD_ZERO_RST = 8'd5;
    localparam logic [BYTE_W-1:0] PERIOD_ONE_RST  = 8'd8;
    localparam logic [BYTE_W-1:0] PERIOD_TWO_RST  = 8'd20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ONE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TWO  = 2'd3;

    // Request kinds on the input tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Row driver command issued with a row step
    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_SHIFT       = 2'd1,
        ACT_LOAD_FIRST  = 2'd2,
        ACT_LOAD_SECOND = 2'd3
    } t_row_action;

endpackage

@@ rtl/core/lmbs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lmbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/led_matrix_bitplane_scanner_top.sv @@
// Top level of the LED matrix bit-plane scanner: tick counter, row sequencer, frame store.
//
//  Channel   Dir  Handshake                 Payload
//  -------   ---  ------------------------  -------------------------------------------
//  s (req)   in   i_s_tvalid / o_s_tready   tuser: req_type; tdata: plane,row,half,byte
//  m (res)   out  o_m_tvalid / i_m_tready   tuser: row_stepped; tdata: cols,action,row,plane
//  cfg       in   i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// One beat in per cycle while not stalled, one result beat out per input beat via
// the frame store read, then the output register. The frame store read for a row
// step is issued in the cycle the tick is taken; the counter and row state update
// the same cycle, so ticks follow back to back. Stalls on the result side hold the
// read data and stop intake only once both the read stage and output register are
// full. Reset is synchronous; frame store entries read as zero until written.
module led_matrix_bitplane_scanner_top #(
    parameter int unsigned ROWS   = 16,
    parameter int unsigned PLANES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // wr_plane[1:0], wr_row[5:2], wr_half[6], wr_data[14:7]
    input  logic        i_s_tuser,  // req_type[0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // columns_low[7:0], columns_high[15:8],
                                    // row_action[17:16], shown_row[21:18], shown_plane[23:22]
    output logic        o_m_tuser,  // row_stepped[0]
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int unsigned DEPTH = PLANES * 16;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [lmbs_pkg::ROW_W-1:0]   ROW_LAST   = lmbs_pkg::ROW_W'(ROWS - 1);
    localparam logic [lmbs_pkg::PLANE_W-1:0] PLANE_LAST = lmbs_pkg::PLANE_W'(PLANES - 1);

    // Input fields
    logic [1:0] s_plane;
    logic [3:0] s_row;
    logic       s_half;
    logic [7:0] s_byte;
    assign s_plane = i_s_tdata[1:0];
    assign s_row   = i_s_tdata[5:2];
    assign s_half  = i_s_tdata[6];
    assign s_byte  = i_s_tdata[14:7];

    // Configuration registers
    logic       r_scan_enable;
    logic [7:0] r_period_zero, r_period_one, r_period_two;

    // Scan state
    logic [7:0] r_tick_cnt, n_tick_cnt;
    logic [7:0] r_compare, n_compare;
    logic [3:0] r_next_row, n_next_row;
    logic [1:0] r_next_plane, n_next_plane;
    logic [3:0] r_shown_row, n_shown_row;
    logic [1:0] r_shown_plane, n_shown_plane;
    logic [15:0] r_shown_cols;

    // Frame store valid bits, one per byte
    logic [DEPTH-1:0] r_vld_lo, r_vld_hi;

    // Read stage
    logic       r_s1_valid;
    logic       r_s1_step;
    logic       r_s1_en;
    logic       r_s1_vlo, r_s1_vhi;
    lmbs_pkg::t_row_action r_s1_action;
    logic [3:0] r_s1_row;
    logic [1:0] r_s1_plane;

    // Output register
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        r_out_user;

    logic        accept, advance, step, wr_ok;
    logic        we_lo, we_hi;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rd_lo, rd_hi;
    logic [15:0] s1_cols;
    lmbs_pkg::t_row_action step_action;
    logic [7:0]  plane_period;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || advance;
    assign accept     = i_s_tvalid && o_s_tready;

    // Frame write decode, out-of-range writes dropped
    assign wr_ok = accept && (i_s_tuser == lmbs_pkg::REQ_WRITE)
                   && (s_plane <= PLANE_LAST) && (s_row <= ROW_LAST);
    assign we_lo = wr_ok && !s_half;
    assign we_hi = wr_ok && s_half;
    assign waddr = AW'({s_plane, s_row});
    assign raddr = AW'({r_next_plane, r_next_row});

    // Tick match
    assign step = accept && (i_s_tuser == lmbs_pkg::REQ_TICK) && r_scan_enable
                  && (r_tick_cnt == r_compare);

    always_comb begin
        case (r_next_plane)
            2'd0:    plane_period = r_period_zero;
            2'd1:    plane_period = r_period_one;
            default: plane_period = r_period_two;
        endcase
    end

    always_comb begin
        if (r_next_row == '0) begin
            step_action = lmbs_pkg::ACT_LOAD_FIRST;
        end else if (r_next_row == lmbs_pkg::SECOND_BANK_ROW) begin
            step_action = lmbs_pkg::ACT_LOAD_SECOND;
        end else begin
            step_action = lmbs_pkg::ACT_SHIFT;
        end
    end

    // Next scan state for the accepted beat
    always_comb begin
        n_tick_cnt    = r_tick_cnt;
        n_compare     = r_compare;
        n_next_row    = r_next_row;
        n_next_plane  = r_next_plane;
        n_shown_row   = r_shown_row;
        n_shown_plane = r_shown_plane;
        if (step) begin
            n_tick_cnt    = '0;
            n_shown_row   = r_next_row;
            n_shown_plane = r_next_plane;
            if (r_next_row == '0) begin
                n_compare = plane_period;
            end
            if (r_next_row == ROW_LAST) begin
                n_next_row   = '0;
                n_next_plane = (r_next_plane == PLANE_LAST) ? '0 : r_next_plane + 2'd1;
            end else begin
                n_next_row = r_next_row + 4'd1;
            end
        end else if (accept && (i_s_tuser == lmbs_pkg::REQ_TICK) && r_scan_enable) begin
            n_tick_cnt = r_tick_cnt + 8'd1;
        end
        // re-enable restarts the row timer
        if (i_cfg_we && (i_cfg_index == lmbs_pkg::CFG_SCAN_ENABLE)
            && i_cfg_wdata[0] && !r_scan_enable) begin
            n_tick_cnt = '0;
            n_compare  = lmbs_pkg::INITIAL_COMPARE;
        end
    end

    // Scan state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable <= 1'b1;
            r_period_zero <= lmbs_pkg::PERIOD_ZERO_RST;
            r_period_one  <= lmbs_pkg::PERIOD_ONE_RST;
            r_period_two  <= lmbs_pkg::PERIOD_TWO_RST;
            r_tick_cnt    <= '0;
            r_compare     <= lmbs_pkg::INITIAL_COMPARE;
            r_next_row    <= '0;
            r_next_plane  <= '0;
            r_shown_row   <= '0;
            r_shown_plane <= '0;
        end else begin
            r_tick_cnt    <= n_tick_cnt;
            r_compare     <= n_compare;
            r_next_row    <= n_next_row;
            r_next_plane  <= n_next_plane;
            r_shown_row   <= n_shown_row;
            r_shown_plane <= n_shown_plane;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lmbs_pkg::CFG_SCAN_ENABLE: r_scan_enable <= i_cfg_wdata[0];
                    lmbs_pkg::CFG_PERIOD_ZERO: r_period_zero <= i_cfg_wdata;
                    lmbs_pkg::CFG_PERIOD_ONE:  r_period_one  <= i_cfg_wdata;
                    lmbs_pkg::CFG_PERIOD_TWO:  r_period_two  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Valid bits: bytes never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lo <= '0;
            r_vld_hi <= '0;
        end else begin
            if (we_lo) r_vld_lo[waddr] <= 1'b1;
            if (we_hi) r_vld_hi[waddr] <= 1'b1;
        end
    end

    // Frame store, one RAM per column half
    lmbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (we_lo),
        .i_waddr (waddr),
        .i_wdata (s_byte),
        .i_re    (step),
        .i_raddr (raddr),
        .o_rdata (rd_lo)
    );

    lmbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (we_hi),
        .i_waddr (waddr),
        .i_wdata (s_byte),
        .i_re    (step),
        .i_raddr (raddr),
        .o_rdata (rd_hi)
    );

    // Read stage: snapshot of the beat while the store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_step   <= step;
            r_s1_en     <= r_scan_enable;
            r_s1_action <= step ? step_action : lmbs_pkg::ACT_NONE;
            r_s1_row    <= n_shown_row;
            r_s1_plane  <= n_shown_plane;
            r_s1_vlo    <= r_vld_lo[raddr];
            r_s1_vhi    <= r_vld_hi[raddr];
        end
    end

    // Columns after this beat: fresh row data on a step, else what is shown
    assign s1_cols = r_s1_step ? {(r_s1_vhi ? rd_hi : 8'd0), (r_s1_vlo ? rd_lo : 8'd0)}
                               : r_shown_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_cols <= '0;
        end else if (i_cfg_we && (i_cfg_index == lmbs_pkg::CFG_SCAN_ENABLE)
                     && !i_cfg_wdata[0] && r_scan_enable) begin
            r_shown_cols <= '0;
        end else if (r_s1_valid && advance && r_s1_step) begin
            r_shown_cols <= s1_cols;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            if (r_s1_en) begin
                r_out_data <= {r_s1_plane, r_s1_row, r_s1_action, s1_cols};
                r_out_user <= r_s1_step;
            end else begin
                r_out_data <= '0;
                r_out_user <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

@@ rtl/core/lmbs_checker.sv @@
// Port-level checks for the LED matrix bit-plane scanner, bound to the top level.
module lmbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser
);

    // Result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result beat changed under stall");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A new result follows an accepted request through the read stage and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result without matching request");

    // A step onto row 0 loads the first row register
    a_row0_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && (o_m_tdata[21:18] == 4'd0)
        |-> o_m_tdata[17:16] == lmbs_pkg::ACT_LOAD_FIRST)
        else $error("row 0 step without first register load");

endmodule

bind led_matrix_bitplane_scanner_top lmbs_checker u_lmbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

@@ verif/tb.sv @@
// Testbench for the LED matrix bit-plane scanner: stream driver, monitor and scan predictor.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned SCAN_ROWS   = 16;
    localparam int unsigned SCAN_PLANES = 3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // One request beat: a timer tick or a frame byte write
    typedef struct {
        logic       req;
        logic [1:0] plane;
        logic [3:0] row;
        logic       half;
        logic [7:0] data;
    } t_scan_req;

    // One result beat: the drive now shown
    typedef struct {
        logic [7:0]  cols_lo;
        logic [7:0]  cols_hi;
        lmbs_pkg::t_row_action act;
        logic [3:0]  row;
        logic [1:0]  plane;
        logic        stepped;
    } t_drive;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    led_matrix_bitplane_scanner_top #(
        .ROWS   (SCAN_ROWS),
        .PLANES (SCAN_PLANES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state
    logic [7:0] frame_bytes [96];
    logic       sc_en;
    logic [7:0] sc_period [3];
    logic [7:0] sc_count;
    logic [7:0] sc_compare;
    logic [3:0] sc_next_row;
    logic [1:0] sc_next_plane;
    logic [15:0] sc_cols;
    logic [3:0] sc_row;
    logic [1:0] sc_plane;

    t_scan_req pending [$];
    t_drive    drive_q [$];
    t_scan_req cur_req;
    bit        s_taken = 1'b0;
    int        s_gap = 0;
    int        m_gap = 0;
    bit        calm = 1'b0;
    int        n_err = 0;
    int        n_beats = 0;
    int        n_steps = 0;
    int        n_frames = 0;
    int        n_writes = 0;

    function automatic int byte_addr(logic [1:0] plane, logic [3:0] row, logic half);
        return int'(plane) * 32 + int'(row) * 2 + int'(half);
    endfunction

    // Register write as the block sees it
    function automatic void apply_reg(logic [1:0] idx, logic [7:0] val);
        case (idx)
            lmbs_pkg::CFG_SCAN_ENABLE: begin
                if (val[0] && !sc_en) begin
                    sc_count   = '0;
                    sc_compare = lmbs_pkg::INITIAL_COMPARE;
                end else if (!val[0] && sc_en) begin
                    sc_cols = '0;
                end
                sc_en = val[0];
            end
            lmbs_pkg::CFG_PERIOD_ZERO: sc_period[0] = val;
            lmbs_pkg::CFG_PERIOD_ONE:  sc_period[1] = val;
            default:                   sc_period[2] = val;
        endcase
    endfunction

    // Expected drive after one accepted request
    function automatic t_drive scan_predict(t_scan_req r);
        t_drive d;
        lmbs_pkg::t_row_action act;
        logic stepped;
        act = lmbs_pkg::ACT_NONE;
        stepped = 1'b0;
        if (r.req == lmbs_pkg::REQ_WRITE) begin
            if (r.plane < SCAN_PLANES && r.row < SCAN_ROWS)
                frame_bytes[byte_addr(r.plane, r.row, r.half)] = r.data;
        end else if (sc_en) begin
            if (sc_count == sc_compare) begin
                sc_count = '0;
                stepped = 1'b1;
                if (sc_next_row == 0) begin
                    act = lmbs_pkg::ACT_LOAD_FIRST;
                    sc_compare = sc_period[sc_next_plane];
                end else if (sc_next_row == lmbs_pkg::SECOND_BANK_ROW) begin
                    act = lmbs_pkg::ACT_LOAD_SECOND;
                end else begin
                    act = lmbs_pkg::ACT_SHIFT;
                end
                sc_cols = {frame_bytes[byte_addr(sc_next_plane, sc_next_row, 1'b1)],
                           frame_bytes[byte_addr(sc_next_plane, sc_next_row, 1'b0)]};
                sc_row = sc_next_row;
                sc_plane = sc_next_plane;
                if (sc_next_row == SCAN_ROWS - 1) begin
                    sc_next_row = '0;
                    sc_next_plane = (sc_next_plane == SCAN_PLANES - 1) ? 2'd0
                                                                       : sc_next_plane + 2'd1;
                end else begin
                    sc_next_row = sc_next_row + 4'd1;
                end
            end else begin
                sc_count = sc_count + 8'd1;
            end
        end
        if (sc_en) begin
            d.cols_lo = sc_cols[7:0];
            d.cols_hi = sc_cols[15:8];
            d.act     = act;
            d.row     = sc_row;
            d.plane   = sc_plane;
            d.stepped = stepped;
        end else begin
            d.cols_lo = '0;
            d.cols_hi = '0;
            d.act     = lmbs_pkg::ACT_NONE;
            d.row     = '0;
            d.plane   = '0;
            d.stepped = 1'b0;
        end
        return d;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
            n_err++;
        end
    endfunction

    // Request driver: next beat at a falling edge once the last was taken and no gap runs
    always @(negedge i_clk) begin : source
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            s_taken = 1'b0;
            if (s_gap > 0 && !calm) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur_req = pending.pop_front();
                s_tdata  <= {1'b0, cur_req.data, cur_req.half, cur_req.row, cur_req.plane};
                s_tuser  <= cur_req.req;
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    s_gap = $urandom_range(1, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in bursts
    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (m_gap > 0 && !calm) begin
            m_gap--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            m_gap = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check result beats, predict on accepted request beats
    always @(posedge i_clk) begin : monitor
        t_drive want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                n_beats++;
                if (drive_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h/%b",
                             $time, m_tdata, m_tuser);
                    n_err++;
                end else begin
                    want = drive_q.pop_front();
                    check_field("columns_low",  int'(want.cols_lo), int'(m_tdata[7:0]));
                    check_field("columns_high", int'(want.cols_hi), int'(m_tdata[15:8]));
                    check_field("row_action",   int'(want.act),     int'(m_tdata[17:16]));
                    check_field("shown_row",    int'(want.row),     int'(m_tdata[21:18]));
                    check_field("shown_plane",  int'(want.plane),   int'(m_tdata[23:22]));
                    check_field("row_stepped",  int'(want.stepped), int'(m_tuser));
                    if (want.stepped) n_steps++;
                    if (want.act == lmbs_pkg::ACT_LOAD_FIRST) n_frames++;
                end
            end
            if (s_tvalid && s_tready) begin
                drive_q.push_back(scan_predict(cur_req));
                if (cur_req.req == lmbs_pkg::REQ_WRITE) n_writes++;
                s_taken = 1'b1;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAIL led_matrix_bitplane_scanner_top");
        $finish;
    end

    task automatic wait_idle();
        while (pending.size() > 0 || s_tvalid || drive_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        wait_idle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_periods(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
        write_reg(lmbs_pkg::CFG_PERIOD_ZERO, p0);
        write_reg(lmbs_pkg::CFG_PERIOD_ONE, p1);
        write_reg(lmbs_pkg::CFG_PERIOD_TWO, p2);
    endtask

    task automatic queue_write(logic [1:0] plane, logic [3:0] row, logic half, logic [7:0] data);
        t_scan_req r;
        r.req = lmbs_pkg::REQ_WRITE;
        r.plane = plane;
        r.row = row;
        r.half = half;
        r.data = data;
        pending.push_back(r);
    endtask

    // Random requests; tick_pct percent are ticks, the rest byte writes
    task automatic queue_random(int n, int tick_pct);
        t_scan_req r;
        repeat (n) begin
            r.req   = ($urandom_range(0, 99) < tick_pct) ? lmbs_pkg::REQ_TICK
                                                         : lmbs_pkg::REQ_WRITE;
            r.plane = 2'($urandom_range(0, 3));
            r.row   = 4'($urandom_range(0, 15));
            r.half  = 1'($urandom_range(0, 1));
            r.data  = 8'($urandom);
            pending.push_back(r);
        end
    endtask

    initial begin : stimulus
        sc_en = 1'b1;
        sc_period[0] = lmbs_pkg::PERIOD_ZERO_RST;
        sc_period[1] = lmbs_pkg::PERIOD_ONE_RST;
        sc_period[2] = lmbs_pkg::PERIOD_TWO_RST;
        sc_count = '0;
        sc_compare = lmbs_pkg::INITIAL_COMPARE;
        sc_next_row = '0;
        sc_next_plane = '0;
        sc_cols = '0;
        sc_row = '0;
        sc_plane = '0;
        foreach (frame_bytes[k]) frame_bytes[k] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: store corners, ignored out-of-range plane, first steps
        queue_write(2'd0, 4'd0, 1'b0, 8'hFF);
        queue_write(2'd0, 4'd0, 1'b1, 8'h01);
        queue_write(2'd1, 4'd8, 1'b0, 8'h80);
        queue_write(2'd2, 4'd15, 1'b1, 8'hFF);
        queue_write(2'd3, 4'd15, 1'b1, 8'h55);
        queue_write(2'd3, 4'd0, 1'b0, 8'hAA);
        queue_write(2'd0, 4'd1, 1'b0, 8'hA5);
        queue_write(2'd0, 4'd1, 1'b1, 8'h5A);
        queue_random(21, 100);
        queue_write(2'd0, 4'd0, 1'b0, 8'h00);
        queue_random(6, 100);

        // Disabled: ticks do nothing, writes still land; then resume
        write_reg(lmbs_pkg::CFG_SCAN_ENABLE, 8'h00);
        queue_random(2, 100);
        queue_write(2'd1, 4'd3, 1'b1, 8'h3C);
        write_reg(lmbs_pkg::CFG_SCAN_ENABLE, 8'h01);

        // Random phases over several period settings
        set_periods(8'd0, 8'd0, 8'd0);
        queue_random(80, 80);
        set_periods(8'd1, 8'd2, 8'd3);
        queue_random(80, 70);
        write_reg(lmbs_pkg::CFG_SCAN_ENABLE, 8'h00);
        queue_random(30, 50);
        write_reg(lmbs_pkg::CFG_SCAN_ENABLE, 8'hFF);
        set_periods(8'd255, 8'd0, 8'd1);
        queue_random(350, 95);

        // Last stretch without idling on either side
        set_periods(8'd2, 8'd4, 8'd255);
        calm = 1'b1;
        queue_random(80, 85);

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d result beats: %0d byte writes, %0d row steps, %0d plane starts,",
                 n_beats, n_writes, n_steps, n_frames);
        $display("over enable toggling and periods from 0 to 255 with random stalls.");
        if (n_err == 0 && drive_q.size() == 0) begin
            $display("PASS led_matrix_bitplane_scanner_top");
        end else begin
            $display("%0d errors, %0d results outstanding", n_err, drive_q.size());
            $display("FAIL led_matrix_bitplane_scanner_top");
        end
        $finish;
    end

endmodule

@@ led_matrix_bitplane_scanner_top.f @@
rtl/core/lmbs_pkg.sv
rtl/core/lmbs_ram.sv
rtl/core/led_matrix_bitplane_scanner_top.sv
rtl/core/lmbs_checker.sv
verif/tb.sv
